// ===== design/aip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_pkg: shared types and constants of the ASCII integer parser
// Word formats, configuration register indexes, parse phases and the
// character codes the parser reacts to.
// ----------------------------------------------------------------------------
package aip_pkg;

  localparam int unsigned CharWidth   = 8;
  localparam int unsigned ValueWidth  = 64;
  localparam int unsigned CountWidth  = 16;
  localparam int unsigned BaseWidth   = 6;
  localparam int unsigned CfgIdxWidth = 4;
  localparam int unsigned CfgDataWidth = 8;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] CfgNumberBase = 4'd0;
  localparam logic [CfgIdxWidth-1:0] CfgSignedMode = 4'd1;

  // Register reset values.
  localparam logic [BaseWidth-1:0] NumberBaseReset = 6'd10;
  localparam logic                 SignedModeReset = 1'b1;

  // Bases chosen by prefix detection.
  localparam logic [BaseWidth-1:0] BaseOctal   = 6'd8;
  localparam logic [BaseWidth-1:0] BaseDecimal = 6'd10;
  localparam logic [BaseWidth-1:0] BaseHex     = 6'd16;

  // Character codes.
  localparam logic [CharWidth-1:0] CharSpace = 8'h20;
  localparam logic [CharWidth-1:0] CharTab   = 8'h09;
  localparam logic [CharWidth-1:0] CharLf    = 8'h0A;
  localparam logic [CharWidth-1:0] CharCr    = 8'h0D;
  localparam logic [CharWidth-1:0] CharFf    = 8'h0C;
  localparam logic [CharWidth-1:0] CharVt    = 8'h0B;
  localparam logic [CharWidth-1:0] CharMinus = 8'h2D;
  localparam logic [CharWidth-1:0] CharPlus  = 8'h2B;
  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharNine  = 8'h39;
  localparam logic [CharWidth-1:0] CharLowA  = 8'h61;
  localparam logic [CharWidth-1:0] CharLowF  = 8'h66;
  localparam logic [CharWidth-1:0] CharUpA   = 8'h41;
  localparam logic [CharWidth-1:0] CharUpF   = 8'h46;
  localparam logic [CharWidth-1:0] CharLowX  = 8'h78;
  localparam logic [CharWidth-1:0] CharUpX   = 8'h58;

  // Digit value 16 marks a character that is no hex digit.
  localparam logic [4:0] DigitNone = 5'd16;

  typedef enum logic [4:0] {
    PhDone   = 5'b00001,
    PhSpace  = 5'b00010,
    PhPrefix = 5'b00100,
    PhXcheck = 5'b01000,
    PhDigits = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [CharWidth-1:0] char_in;
    logic                 string_start;
  } aip_in_t;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic [CountWidth-1:0] consumed_count;
  } aip_out_t;

endpackage

// ===== design/ascii_integer_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_integer_parser_top: streaming text-to-integer converter
// Parses one character per word like strtoll and strtoull, with whitespace
// skipping, optional sign and, in base zero, detection of a 0 or 0x prefix.
// ----------------------------------------------------------------------------
//
// Channel | Direction | Handshake           | Word
// --------+-----------+---------------------+-------------------------------
// in      | input     | in_valid / in_ready | char_in, string_start
// out     | output    | out_valid/out_ready | value, consumed_count
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// The block takes one character word per cycle unless the output stalls. A
// word first lands in an input register. The parse step runs on it (one 64
// by 6 bit multiply-add is the longest path) and writes the parser state and
// the result register, so a result passes the input register and then the
// result register before it can be taken. The input register only drains
// while the result register is empty or being read, so a stalled output
// backs up into in_ready after one word of slack. Reset returns the registers
// to base ten and signed mode and leaves the parser waiting for a string
// start. Configuration writes are always taken and act in the next cycle.
module ascii_integer_parser_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  aip_pkg::aip_in_t                      in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output aip_pkg::aip_out_t                     out_data_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [aip_pkg::CfgIdxWidth-1:0]       cfg_index_i,
  input  logic [aip_pkg::CfgDataWidth-1:0]      cfg_data_i
);

  // Configuration registers.
  logic [aip_pkg::BaseWidth-1:0] number_base_q;
  logic                          signed_mode_q;

  // Input register.
  logic             in_valid_q;
  aip_pkg::aip_in_t in_q;

  // Parser state.
  aip_pkg::phase_e                phase_q, phase_d;
  logic [aip_pkg::ValueWidth-1:0] acc_q, acc_d;
  logic [aip_pkg::BaseWidth-1:0]  base_q, base_d;
  logic                           neg_q, neg_d;
  logic [aip_pkg::CountWidth-1:0] cnt_q, cnt_d;

  // Result register.
  logic              out_valid_q;
  aip_pkg::aip_out_t out_q;

  logic                           advance;
  logic                           emit;
  logic                           consume;
  logic [aip_pkg::ValueWidth-1:0] acc_eff;
  logic [aip_pkg::CountWidth-1:0] cnt_eff;
  logic [4:0]                     digit;
  logic                           is_space;

  // The word in the input register is parsed when the result slot is free or being read.
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= aip_pkg::NumberBaseReset;
      signed_mode_q <= aip_pkg::SignedModeReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        aip_pkg::CfgNumberBase: number_base_q <= cfg_data_i[aip_pkg::BaseWidth-1:0];
        aip_pkg::CfgSignedMode: signed_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (in_q.char_in) inside
      aip_pkg::CharSpace, aip_pkg::CharTab, aip_pkg::CharLf,
      aip_pkg::CharCr, aip_pkg::CharFf, aip_pkg::CharVt: is_space = 1'b1;
      default: is_space = 1'b0;
    endcase
  end

  // Hex digit value of the character, or DigitNone.
  always_comb begin
    if (in_q.char_in >= aip_pkg::CharZero && in_q.char_in <= aip_pkg::CharNine) begin
      digit = 5'(in_q.char_in - aip_pkg::CharZero);
    end else if (in_q.char_in >= aip_pkg::CharLowA && in_q.char_in <= aip_pkg::CharLowF) begin
      digit = 5'(in_q.char_in - aip_pkg::CharLowA + 8'd10);
    end else if (in_q.char_in >= aip_pkg::CharUpA && in_q.char_in <= aip_pkg::CharUpF) begin
      digit = 5'(in_q.char_in - aip_pkg::CharUpA + 8'd10);
    end else begin
      digit = aip_pkg::DigitNone;
    end
  end

  // A string start wipes the state before the character is looked at.
  assign acc_eff = in_q.string_start ? '0 : acc_q;
  assign cnt_eff = in_q.string_start ? '0 : cnt_q;

  // One parse step. The phases fall through into each other within the
  // step, just as a character that ends one phase is tried by the next.
  always_comb begin
    logic go;
    go      = 1'b1;
    emit    = 1'b0;
    consume = 1'b0;
    phase_d = in_q.string_start ? aip_pkg::PhSpace : phase_q;
    base_d  = in_q.string_start ? number_base_q : base_q;
    neg_d   = in_q.string_start ? 1'b0 : neg_q;
    acc_d   = acc_eff;

    if (phase_d == aip_pkg::PhDone) begin
      go = 1'b0;
    end

    if (go && phase_d == aip_pkg::PhSpace) begin
      if (is_space) begin
        consume = 1'b1;
        go      = 1'b0;
      end else begin
        phase_d = aip_pkg::PhPrefix;
        if (signed_mode_q && in_q.char_in == aip_pkg::CharMinus) begin
          neg_d   = 1'b1;
          consume = 1'b1;
          go      = 1'b0;
        end else if (signed_mode_q && in_q.char_in == aip_pkg::CharPlus) begin
          consume = 1'b1;
          go      = 1'b0;
        end
      end
    end

    if (go && phase_d == aip_pkg::PhPrefix) begin
      if (base_d == '0) begin
        if (in_q.char_in == aip_pkg::CharZero) begin
          base_d  = aip_pkg::BaseOctal;
          phase_d = aip_pkg::PhXcheck;
          consume = 1'b1;
          go      = 1'b0;
        end else begin
          base_d = aip_pkg::BaseDecimal;
        end
      end
      if (go) begin
        phase_d = aip_pkg::PhDigits;
      end
    end

    if (go && phase_d == aip_pkg::PhXcheck) begin
      phase_d = aip_pkg::PhDigits;
      if (in_q.char_in == aip_pkg::CharLowX || in_q.char_in == aip_pkg::CharUpX) begin
        base_d  = aip_pkg::BaseHex;
        consume = 1'b1;
        go      = 1'b0;
      end
    end

    if (go) begin
      if (digit != aip_pkg::DigitNone && {1'b0, digit} < base_d) begin
        acc_d   = acc_eff * aip_pkg::ValueWidth'(base_d)
                  + aip_pkg::ValueWidth'(digit);
        consume = 1'b1;
      end else begin
        emit    = 1'b1;
        phase_d = aip_pkg::PhDone;
      end
    end

    // The count saturates rather than wraps.
    cnt_d = (consume && cnt_eff != '1) ? cnt_eff + 1'b1 : cnt_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= aip_pkg::PhDone;
      acc_q       <= '0;
      base_q      <= '0;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= emit;
        phase_q     <= phase_d;
        acc_q       <= acc_d;
        base_q      <= base_d;
        neg_q       <= neg_d;
        cnt_q       <= cnt_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance && emit) begin
      out_q.value          <= neg_d ? -acc_eff : acc_eff;
      out_q.consumed_count <= cnt_d;
    end
  end

endmodule

// ===== bench/ascii_integer_parser_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_integer_parser_top_test: self-checking bench for the ASCII parser
// Streams character words through the parser and runs its own copy of the
// parse rules beside it. It checks every result word field by field against
// the oldest prediction, across several base and sign settings, with random
// idling on both channels.
// ----------------------------------------------------------------------------
module ascii_integer_parser_top_test;
  import aip_pkg::*;

  logic clk;
  logic rst_n = 1'b0;

  // Block inputs start at known values before the first clock edge.
  logic                    in_valid  = 1'b0;
  aip_in_t                 in_data   = '0;
  logic                    out_ready = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data  = '0;

  logic     in_ready_o;
  logic     out_valid_o;
  aip_out_t out_data_o;
  logic     cfg_ready_o;

  ascii_integer_parser_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Character words waiting to be sent, and result words still to arrive.
  aip_in_t  pending_words [$];
  aip_out_t expected_results [$];

  // The bench's view of the two configuration registers.
  logic [BaseWidth-1:0] base_setting   = NumberBaseReset;
  logic                 signed_setting = SignedModeReset;

  // Parser state as the bench predicts it.
  phase_e                pred_phase = PhDone;
  logic [ValueWidth-1:0] pred_acc   = '0;
  logic [BaseWidth-1:0]  pred_base  = '0;
  logic                  pred_neg   = 1'b0;
  logic [CountWidth-1:0] pred_count = '0;

  // Idling controls, changed only between phases while the block is idle.
  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;

  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned mismatches = 0;
  aip_out_t    predicted;
  aip_out_t    want;

  logic [CharWidth-1:0] blank_chars [6] = '{CharSpace, CharTab, CharLf, CharCr, CharFf,
                                            CharVt};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case a handshake never completes or a result never shows up.
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Most idle stretches are short; a few are long.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Every consumed character bumps the count, which sticks at its top value.
  function automatic void count_char();
    if (pred_count != '1) pred_count = pred_count + 1'b1;
  endfunction

  // Advances the predicted parser state by one character word. Returns 1 when
  // the word stops the parse, with the result word in res.
  function automatic bit step_parser(input aip_in_t w, output aip_out_t res);
    logic [CharWidth-1:0] c;
    logic [4:0]           d;
    c   = w.char_in;
    res = '0;
    if (w.string_start) begin
      // A new string drops whatever was in flight and latches the base.
      pred_phase = PhSpace;
      pred_acc   = '0;
      pred_neg   = 1'b0;
      pred_count = '0;
      pred_base  = base_setting;
    end
    if (pred_phase == PhDone) return 1'b0;

    if (pred_phase == PhSpace) begin
      if (c inside {CharSpace, CharTab, CharLf, CharCr, CharFf, CharVt}) begin
        count_char();
        return 1'b0;
      end
      // The sign setting is sampled here, at the first non-blank character.
      pred_phase = PhPrefix;
      if (signed_setting) begin
        if (c == CharMinus) begin
          pred_neg = 1'b1;
          count_char();
          return 1'b0;
        end
        if (c == CharPlus) begin
          count_char();
          return 1'b0;
        end
      end
    end

    if (pred_phase == PhPrefix) begin
      if (pred_base == '0) begin
        if (c == CharZero) begin
          pred_base  = BaseOctal;
          pred_phase = PhXcheck;
          count_char();
          return 1'b0;
        end
        pred_base = BaseDecimal;
      end
      pred_phase = PhDigits;
    end

    if (pred_phase == PhXcheck) begin
      pred_phase = PhDigits;
      if (c == CharLowX || c == CharUpX) begin
        pred_base = BaseHex;
        count_char();
        return 1'b0;
      end
    end

    // Only 0-9, a-f and A-F are ever digits, whatever the base.
    d = DigitNone;
    if (c >= CharZero && c <= CharNine) d = 5'(c - CharZero);
    else if (c >= CharLowA && c <= CharLowF) d = 5'(c - CharLowA + 8'd10);
    else if (c >= CharUpA && c <= CharUpF) d = 5'(c - CharUpA + 8'd10);

    if (d != DigitNone && {1'b0, d} < pred_base) begin
      pred_acc = pred_acc * ValueWidth'(pred_base) + ValueWidth'(d);
      count_char();
      return 1'b0;
    end

    res.value          = pred_neg ? ValueWidth'(0) - pred_acc : pred_acc;
    res.consumed_count = pred_count;
    pred_phase         = PhDone;
    return 1'b1;
  endfunction

  // Sender: predicts each accepted word, then puts up the next one after a
  // random gap. Valid stays high with a steady word until it is taken.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      gap_left   = 0;
      pred_phase = PhDone;
      pred_acc   = '0;
      pred_base  = '0;
      pred_neg   = 1'b0;
      pred_count = '0;
    end else begin
      if (in_valid && in_ready_o) begin
        if (step_parser(in_data, predicted)) expected_results.push_back(predicted);
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left > 0 || pending_words.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= pending_words.pop_front();
          if (gaps_on) gap_left = idle_length();
        end
      end
    end
  end

  // Receiver: checks each accepted result word against the oldest prediction
  // and stalls ready at random.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %h / %0d arrived with none expected",
                                    out_data_o.value, out_data_o.consumed_count));
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.value !== want.value) begin
            report_mismatch($sformatf("value %h, expected %h", out_data_o.value, want.value));
          end
          if (out_data_o.consumed_count !== want.consumed_count) begin
            report_mismatch($sformatf("consumed_count %0d, expected %0d",
                                      out_data_o.consumed_count, want.consumed_count));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (stalls_on) stall_left = idle_length();
      end
    end
  end

  task automatic push_word(input logic [CharWidth-1:0] c, input logic start);
    aip_in_t w;
    w.char_in      = c;
    w.string_start = start;
    pending_words.push_back(w);
  endtask

  // Queues one random string. Most are well formed: blanks, a sign, a prefix,
  // digits that fit the base and a terminator. The rest are raw noise with
  // random string starts, or strings cut off before their terminator. Bytes
  // after the terminator are not counted, since the block ignores them.
  task automatic push_random_string(inout int unsigned tally);
    logic [CharWidth-1:0] text [$];
    int unsigned r;
    int unsigned n;
    int unsigned eff;
    int unsigned v;
    bit          zero_prefix;
    bit          hex_prefix;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) push_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      tally += n;
      return;
    end

    repeat ($urandom_range(0, 1) ? $urandom_range(1, 3) : 0) begin
      text.push_back(blank_chars[$urandom_range(0, 5)]);
    end
    r = $urandom_range(0, 9);
    if (r < 3) text.push_back(CharMinus);
    else if (r < 5) text.push_back(CharPlus);
    r = $urandom_range(0, 9);
    zero_prefix = (r < 2);
    hex_prefix  = (r >= 2 && r < 5);
    if (zero_prefix || hex_prefix) text.push_back(CharZero);
    if (hex_prefix) text.push_back($urandom_range(0, 1) ? CharLowX : CharUpX);

    // Pick digits below the base the parser will most likely settle on.
    eff = base_setting;
    if (eff == 0) eff = hex_prefix ? 16 : (zero_prefix ? 8 : 10);
    if (eff > 16) eff = 16;
    r = $urandom_range(0, 19);
    n = (r < 14) ? $urandom_range(1, 8) : ((r < 19) ? $urandom_range(9, 25) : 0);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 15);
      else v = $urandom_range(0, eff - 1);
      if (v < 10) text.push_back(CharZero + 8'(v));
      else text.push_back(($urandom_range(0, 1) ? CharLowA : CharUpA) + 8'(v - 10));
    end

    r = $urandom_range(0, 19);
    if (r < 14) text.push_back(8'h00);
    else if (r < 18) text.push_back(8'($urandom_range(0, 255)));

    foreach (text[k]) push_word(text[k], k == 0);
    tally += text.size();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) push_word(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic fill_random(input int unsigned quota);
    int unsigned tally;
    tally = 0;
    while (tally < quota) push_random_string(tally);
  endtask

  // Waits until every queued word has gone and every result has arrived,
  // then lets the block drain a word that causes no result.
  task automatic wait_idle();
    do @(negedge clk); while (pending_words.size() != 0 || in_valid ||
                              expected_results.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_register(input logic [CfgIdxWidth-1:0] idx,
                                input logic [CfgDataWidth-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == CfgNumberBase) base_setting = data[BaseWidth-1:0];
    else if (idx == CfgSignedMode) signed_setting = data[0];
  endtask

  // Writes both registers and picks the idling for the next phase. Returns
  // on a falling edge so that queue updates never race the sender.
  task automatic set_config(input logic [BaseWidth-1:0] base, input logic sgn,
                            input bit gaps, input bit stalls);
    write_register(CfgNumberBase, {2'b00, base});
    write_register(CfgSignedMode, {7'd0, sgn});
    @(negedge clk);
    gaps_on   = gaps;
    stalls_on = stalls;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings, base ten and signed. Every blank character, a plus sign
    // and an all-ones stop byte: 9 after eight consumed characters.
    push_word(CharSpace, 1'b1);
    push_word(CharTab, 1'b0);
    push_word(CharLf, 1'b0);
    push_word(CharCr, 1'b0);
    push_word(CharFf, 1'b0);
    push_word(CharVt, 1'b0);
    push_word(CharPlus, 1'b0);
    push_word(CharNine, 1'b0);
    push_word(8'hFF, 1'b0);
    // A minus sign alone still counts as consumed.
    push_word(CharMinus, 1'b1);
    push_word(8'h00, 1'b0);
    // A new string start abandons the one in progress without a result.
    push_word(CharZero + 8'd7, 1'b1);
    push_word(CharZero + 8'd1, 1'b1);
    push_word(8'h00, 1'b0);
    // This string stays open across the register writes below.
    push_word(CharSpace, 1'b1);
    wait_idle();

    // Auto base, unsigned. The open string keeps its latched base ten, so
    // "09" reads as nine rather than as an octal prefix.
    set_config(6'd0, 1'b0, 1'b1, 1'b1);
    push_word(CharZero, 1'b0);
    push_word(CharNine, 1'b0);
    push_word(8'h00, 1'b0);
    // A bare "0X" prefix stopped by a non-digit letter.
    push_word(CharZero, 1'b1);
    push_word(CharUpX, 1'b0);
    push_word(CharLowF + 8'd1, 1'b0);
    fill_random(50);
    wait_idle();

    // Hex, unsigned: a minus sign is no sign here and stops at once.
    set_config(BaseHex, 1'b0, 1'b1, 1'b0);
    push_word(CharMinus, 1'b1);
    fill_random(50);
    wait_idle();

    // Base one takes only the digit zero.
    set_config(6'd1, 1'b1, 1'b0, 1'b1);
    push_word(CharZero, 1'b1);
    push_word(CharZero, 1'b0);
    push_word(CharZero + 8'd1, 1'b0);
    fill_random(50);
    wait_idle();

    // Base 36 still stops at the first letter past f.
    set_config(6'd36, 1'b0, 1'b0, 1'b0);
    push_word(CharUpF, 1'b1);
    push_word(CharLowF + 8'd1, 1'b0);
    fill_random(50);
    wait_idle();

    set_config(BaseOctal, 1'b1, 1'b1, 1'b1);
    fill_random(50);
    wait_idle();

    set_config(6'd0, 1'b1, 1'b1, 1'b1);
    fill_random(50);
    wait_idle();

    set_config(6'd2, 1'b0, 1'b1, 1'b1);
    fill_random(50);
    wait_idle();

    set_config(BaseDecimal, 1'b1, 1'b1, 1'b0);
    fill_random(50);
    wait_idle();

    // A few phases with settings drawn at random.
    repeat (4) begin
      set_config(6'($urandom_range(0, 36)), 1'($urandom_range(0, 1)), 1'b1, 1'b1);
      fill_random(50);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
